[rtl/core/ecsm_pkg.sv]
// package for the elliptic-curve point unit: widths, field codes, item types,
// datapath command and status structs; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ecsm_pkg;

  localparam int FIELD_BITS   = 16;
  localparam int SCALAR_BITS  = 16;
  localparam int CNT_BITS     = $clog2(SCALAR_BITS);
  localparam int MUL_CNT_BITS = $clog2(FIELD_BITS + 1);
  localparam int CFG_IDX_BITS = 1;

  typedef logic [FIELD_BITS-1:0]  field_t;
  typedef logic [SCALAR_BITS-1:0] scalar_t;

  // operation codes
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_DBL  = 2'd1;
  localparam logic [1:0] OP_SMUL = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_CURVE_A     = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIELD_PRIME = 1'b1;

  localparam field_t CURVE_A_RESET     = FIELD_BITS'(2);
  localparam field_t FIELD_PRIME_RESET = FIELD_BITS'(5);
  localparam field_t MIN_PRIME         = FIELD_BITS'(3);

  typedef struct packed {
    logic [1:0] op;
    field_t     p_x;
    field_t     p_y;
    field_t     q_x;
    field_t     q_y;
    scalar_t    scalar;
  } in_item_t;

  typedef struct packed {
    field_t r_x;
    field_t r_y;
    logic   status;
  } out_item_t;

  // datapath command codes
  localparam logic [3:0] CMD_NOP   = 4'd0;
  localparam logic [3:0] CMD_LOAD  = 4'd1;
  localparam logic [3:0] CMD_MUL   = 4'd2;
  localparam logic [3:0] CMD_ADD   = 4'd3;
  localparam logic [3:0] CMD_SUB   = 4'd4;
  localparam logic [3:0] CMD_MOV   = 4'd5;
  localparam logic [3:0] CMD_CLRR  = 4'd6;
  localparam logic [3:0] CMD_RLDP  = 4'd7;
  localparam logic [3:0] CMD_RLDQ  = 4'd8;
  localparam logic [3:0] CMD_QLDP  = 4'd9;
  localparam logic [3:0] CMD_IINIT = 4'd10;
  localparam logic [3:0] CMD_ESHR  = 4'd11;
  localparam logic [3:0] CMD_KINIT = 4'd12;
  localparam logic [3:0] CMD_KSHL  = 4'd13;
  localparam logic [3:0] CMD_OUT   = 4'd14;

  // working register and operand codes
  localparam logic [4:0] REG_RX     = 5'd0;
  localparam logic [4:0] REG_RY     = 5'd1;
  localparam logic [4:0] REG_QX     = 5'd2;
  localparam logic [4:0] REG_QY     = 5'd3;
  localparam logic [4:0] REG_PX     = 5'd4;
  localparam logic [4:0] REG_PY     = 5'd5;
  localparam logic [4:0] REG_LAM    = 5'd6;
  localparam logic [4:0] REG_T1     = 5'd7;
  localparam logic [4:0] REG_T2     = 5'd8;
  localparam logic [4:0] REG_IA     = 5'd9;
  localparam logic [4:0] REG_IB     = 5'd10;
  localparam logic [4:0] REG_A      = 5'd11;
  localparam logic [4:0] REG_ONE    = 5'd12;
  localparam logic [4:0] REG_RAW_PX = 5'd13;
  localparam logic [4:0] REG_RAW_PY = 5'd14;
  localparam logic [4:0] REG_RAW_QX = 5'd15;
  localparam logic [4:0] REG_RAW_QY = 5'd16;
  localparam logic [4:0] REG_CFG_A  = 5'd17;

  typedef struct packed {
    logic [3:0] code;
    logic [4:0] dst;
    logic [4:0] sa;
    logic [4:0] sb;
    logic       ostat;
  } dp_cmd_t;

  typedef struct packed {
    logic       mul_done;
    logic [1:0] op;
    logic       k_zero;
    logic       r_inf;
    logic       q_inf;
    logic       eq_x;
    logic       eq_y;
    logic       ry_zero;
    logic       e_zero;
    logic       e_lsb;
    logic       k_msb;
    logic       cnt_zero;
    logic       out_busy;
  } dp_stat_t;

  function automatic dp_cmd_t mk_cmd(input logic [3:0] code, input logic [4:0] dst,
                                     input logic [4:0] sa, input logic [4:0] sb);
    dp_cmd_t c;
    c.code  = code;
    c.dst   = dst;
    c.sa    = sa;
    c.sb    = sb;
    c.ostat = 1'b0;
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/ecsm_mul.sv]
// bit-serial modular multiplier: (u * v) mod m, one bit of u per cycle
// depends on ecsm_pkg; v must already be below m
`timescale 1ns / 1ps
`default_nettype none

module ecsm_mul (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire ecsm_pkg::field_t u,
  input  wire ecsm_pkg::field_t v,
  input  wire ecsm_pkg::field_t m,
  output logic                 done,
  output ecsm_pkg::field_t     prod
);

  logic                               busy;
  logic [ecsm_pkg::MUL_CNT_BITS-1:0]  cnt;
  ecsm_pkg::field_t                   ushift;
  ecsm_pkg::field_t                   vq;
  ecsm_pkg::field_t                   mq;
  ecsm_pkg::field_t                   acc;
  logic [ecsm_pkg::FIELD_BITS+1:0]    t0;
  logic [ecsm_pkg::FIELD_BITS+1:0]    t1;
  logic [ecsm_pkg::FIELD_BITS+1:0]    t2;
  logic [ecsm_pkg::FIELD_BITS+1:0]    m_ext;
  logic                               go;

  assign go    = start && !busy && !done;
  assign m_ext = {2'b00, mq};

  // acc = 2*acc + bit*v, then two conditional subtracts
  always_comb begin
    t0 = {1'b0, acc, 1'b0} + (ushift[ecsm_pkg::FIELD_BITS-1] ? {2'b00, vq} : '0);
    t1 = (t0 >= m_ext) ? (t0 - m_ext) : t0;
    t2 = (t1 >= m_ext) ? (t1 - m_ext) : t1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= ecsm_pkg::MUL_CNT_BITS'(ecsm_pkg::FIELD_BITS);
      end else if (busy) begin
        cnt <= cnt - ecsm_pkg::MUL_CNT_BITS'(1);
        if (cnt == ecsm_pkg::MUL_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ushift <= u;
      vq     <= v;
      mq     <= m;
      acc    <= '0;
    end else if (busy) begin
      acc    <= t2[ecsm_pkg::FIELD_BITS-1:0];
      ushift <= {ushift[ecsm_pkg::FIELD_BITS-2:0], 1'b0};
    end
  end

  assign prod = acc;

endmodule

`default_nettype wire

[rtl/core/ecsm_dp.sv]
// datapath: config registers, working registers, modular add/sub, multiplier,
// scalar shifter and output register; depends on ecsm_pkg and ecsm_mul
`timescale 1ns / 1ps
`default_nettype none

module ecsm_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire ecsm_pkg::dp_cmd_t                      cmd,
  output ecsm_pkg::dp_stat_t                          stat,
  input  wire ecsm_pkg::in_item_t                     in_item,
  input  wire logic                                   cfg_we,
  input  wire logic [ecsm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire ecsm_pkg::field_t                       cfg_data,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output ecsm_pkg::out_item_t                         out_item
);

  ecsm_pkg::field_t curve_a, field_prime, m;
  ecsm_pkg::in_item_t in_q;
  ecsm_pkg::field_t rx, ry, qx, qy, px, py, lam, t1, t2, ia, ib, ar, e;
  ecsm_pkg::scalar_t k;
  logic [ecsm_pkg::CNT_BITS-1:0] cnt;
  ecsm_pkg::field_t va, vb, wr_val, prod;
  logic [ecsm_pkg::FIELD_BITS:0] s_add, s_sub;
  logic mul_done, wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_a     <= ecsm_pkg::CURVE_A_RESET;
      field_prime <= ecsm_pkg::FIELD_PRIME_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ecsm_pkg::CFG_CURVE_A:     curve_a     <= cfg_data;
        ecsm_pkg::CFG_FIELD_PRIME: field_prime <= cfg_data;
        default: ;
      endcase
    end
  end

  assign m = (field_prime < ecsm_pkg::MIN_PRIME) ? ecsm_pkg::MIN_PRIME : field_prime;

  function automatic ecsm_pkg::field_t pick(input logic [4:0] code,
      input ecsm_pkg::field_t rx_i, ry_i, qx_i, qy_i, px_i, py_i, lam_i, t1_i, t2_i,
      ia_i, ib_i, ar_i, ca_i, input ecsm_pkg::in_item_t raw);
    ecsm_pkg::field_t r;
    case (code)
      ecsm_pkg::REG_RX:     r = rx_i;
      ecsm_pkg::REG_RY:     r = ry_i;
      ecsm_pkg::REG_QX:     r = qx_i;
      ecsm_pkg::REG_QY:     r = qy_i;
      ecsm_pkg::REG_PX:     r = px_i;
      ecsm_pkg::REG_PY:     r = py_i;
      ecsm_pkg::REG_LAM:    r = lam_i;
      ecsm_pkg::REG_T1:     r = t1_i;
      ecsm_pkg::REG_T2:     r = t2_i;
      ecsm_pkg::REG_IA:     r = ia_i;
      ecsm_pkg::REG_IB:     r = ib_i;
      ecsm_pkg::REG_A:      r = ar_i;
      ecsm_pkg::REG_ONE:    r = ecsm_pkg::FIELD_BITS'(1);
      ecsm_pkg::REG_RAW_PX: r = raw.p_x;
      ecsm_pkg::REG_RAW_PY: r = raw.p_y;
      ecsm_pkg::REG_RAW_QX: r = raw.q_x;
      ecsm_pkg::REG_RAW_QY: r = raw.q_y;
      ecsm_pkg::REG_CFG_A:  r = ca_i;
      default:              r = '0;
    endcase
    return r;
  endfunction

  assign va = pick(cmd.sa, rx, ry, qx, qy, px, py, lam, t1, t2, ia, ib, ar, curve_a, in_q);
  assign vb = pick(cmd.sb, rx, ry, qx, qy, px, py, lam, t1, t2, ia, ib, ar, curve_a, in_q);

  // combinational modular add and subtract, operands already below m
  always_comb begin
    s_add = {1'b0, va} + {1'b0, vb};
    if (s_add >= {1'b0, m}) s_add = s_add - {1'b0, m};
    if (va >= vb) s_sub = {1'b0, va} - {1'b0, vb};
    else          s_sub = {1'b0, va} + {1'b0, m} - {1'b0, vb};
  end

  ecsm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.code == ecsm_pkg::CMD_MUL),
    .u     (va),
    .v     (vb),
    .m     (m),
    .done  (mul_done),
    .prod  (prod)
  );

  always_comb begin
    wr_en  = 1'b0;
    wr_val = va;
    case (cmd.code)
      ecsm_pkg::CMD_MUL: begin
        wr_en  = mul_done;
        wr_val = prod;
      end
      ecsm_pkg::CMD_ADD: begin
        wr_en  = 1'b1;
        wr_val = s_add[ecsm_pkg::FIELD_BITS-1:0];
      end
      ecsm_pkg::CMD_SUB: begin
        wr_en  = 1'b1;
        wr_val = s_sub[ecsm_pkg::FIELD_BITS-1:0];
      end
      ecsm_pkg::CMD_MOV: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (cmd.dst)
        ecsm_pkg::REG_RX:  rx  <= wr_val;
        ecsm_pkg::REG_RY:  ry  <= wr_val;
        ecsm_pkg::REG_QX:  qx  <= wr_val;
        ecsm_pkg::REG_QY:  qy  <= wr_val;
        ecsm_pkg::REG_PX:  px  <= wr_val;
        ecsm_pkg::REG_PY:  py  <= wr_val;
        ecsm_pkg::REG_LAM: lam <= wr_val;
        ecsm_pkg::REG_T1:  t1  <= wr_val;
        ecsm_pkg::REG_T2:  t2  <= wr_val;
        ecsm_pkg::REG_IA:  ia  <= wr_val;
        ecsm_pkg::REG_IB:  ib  <= wr_val;
        ecsm_pkg::REG_A:   ar  <= wr_val;
        default: ;
      endcase
    end
    case (cmd.code)
      ecsm_pkg::CMD_LOAD: in_q <= in_item;
      ecsm_pkg::CMD_CLRR: begin
        rx <= '0;
        ry <= '0;
      end
      ecsm_pkg::CMD_RLDP: begin
        rx <= px;
        ry <= py;
      end
      ecsm_pkg::CMD_RLDQ: begin
        rx <= qx;
        ry <= qy;
      end
      ecsm_pkg::CMD_QLDP: begin
        qx <= px;
        qy <= py;
      end
      ecsm_pkg::CMD_IINIT: begin
        ib <= t1;
        ia <= ecsm_pkg::FIELD_BITS'(1);
        e  <= m - ecsm_pkg::FIELD_BITS'(2);
      end
      ecsm_pkg::CMD_ESHR: e <= {1'b0, e[ecsm_pkg::FIELD_BITS-1:1]};
      ecsm_pkg::CMD_KINIT: begin
        k   <= in_q.scalar;
        cnt <= ecsm_pkg::CNT_BITS'(ecsm_pkg::SCALAR_BITS - 1);
      end
      ecsm_pkg::CMD_KSHL: begin
        k   <= {k[ecsm_pkg::SCALAR_BITS-2:0], 1'b0};
        cnt <= cnt - ecsm_pkg::CNT_BITS'(1);
      end
      ecsm_pkg::CMD_OUT: begin
        out_item.r_x    <= rx;
        out_item.r_y    <= ry;
        out_item.status <= cmd.ostat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.code == ecsm_pkg::CMD_OUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    stat.mul_done = mul_done;
    stat.op       = in_q.op;
    stat.k_zero   = (in_q.scalar == '0);
    stat.r_inf    = (rx == '0) && (ry == '0);
    stat.q_inf    = (qx == '0) && (qy == '0);
    stat.eq_x     = (rx == qx);
    stat.eq_y     = (ry == qy);
    stat.ry_zero  = (ry == '0);
    stat.e_zero   = (e == '0);
    stat.e_lsb    = e[0];
    stat.k_msb    = k[ecsm_pkg::SCALAR_BITS-1];
    stat.cnt_zero = (cnt == '0);
    stat.out_busy = out_valid && out_stall;
  end

endmodule

`default_nettype wire

[rtl/core/ecsm_ctrl.sv]
// controller: sequences input reduction, point add, point double, field
// inversion and the double-and-add scan; depends on ecsm_pkg
`timescale 1ns / 1ps
`default_nettype none

module ecsm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ecsm_pkg::dp_stat_t stat,
  output ecsm_pkg::dp_cmd_t       cmd
);

  localparam logic [5:0] ST_IDLE  = 6'd0;
  localparam logic [5:0] ST_RA    = 6'd1;
  localparam logic [5:0] ST_RPX   = 6'd2;
  localparam logic [5:0] ST_RPY   = 6'd3;
  localparam logic [5:0] ST_RQX   = 6'd4;
  localparam logic [5:0] ST_RQY   = 6'd5;
  localparam logic [5:0] ST_DISP  = 6'd6;
  localparam logic [5:0] ST_KINIT = 6'd7;
  localparam logic [5:0] ST_KQ    = 6'd8;
  localparam logic [5:0] ST_KFIND = 6'd9;
  localparam logic [5:0] ST_KNEXT = 6'd10;
  localparam logic [5:0] ST_ACHK  = 6'd11;
  localparam logic [5:0] ST_A1    = 6'd12;
  localparam logic [5:0] ST_A2    = 6'd13;
  localparam logic [5:0] ST_A3    = 6'd14;
  localparam logic [5:0] ST_A4    = 6'd15;
  localparam logic [5:0] ST_A5    = 6'd16;
  localparam logic [5:0] ST_A6    = 6'd17;
  localparam logic [5:0] ST_A7    = 6'd18;
  localparam logic [5:0] ST_A8    = 6'd19;
  localparam logic [5:0] ST_A9    = 6'd20;
  localparam logic [5:0] ST_A10   = 6'd21;
  localparam logic [5:0] ST_DCHK  = 6'd22;
  localparam logic [5:0] ST_D1    = 6'd23;
  localparam logic [5:0] ST_D2    = 6'd24;
  localparam logic [5:0] ST_D3    = 6'd25;
  localparam logic [5:0] ST_D4    = 6'd26;
  localparam logic [5:0] ST_D5    = 6'd27;
  localparam logic [5:0] ST_D6    = 6'd28;
  localparam logic [5:0] ST_D7    = 6'd29;
  localparam logic [5:0] ST_D8    = 6'd30;
  localparam logic [5:0] ST_D9    = 6'd31;
  localparam logic [5:0] ST_D10   = 6'd32;
  localparam logic [5:0] ST_D11   = 6'd33;
  localparam logic [5:0] ST_D12   = 6'd34;
  localparam logic [5:0] ST_D13   = 6'd35;
  localparam logic [5:0] ST_INV0  = 6'd36;
  localparam logic [5:0] ST_INVL  = 6'd37;
  localparam logic [5:0] ST_INVM  = 6'd38;
  localparam logic [5:0] ST_INVS  = 6'd39;
  localparam logic [5:0] ST_INVSH = 6'd40;
  localparam logic [5:0] ST_FDBL  = 6'd41;
  localparam logic [5:0] ST_FADD  = 6'd42;
  localparam logic [5:0] ST_OUT   = 6'd43;

  logic [5:0] state, state_next;
  logic in_add, in_add_next;
  logic inv_dbl, inv_dbl_next;
  logic stat_q, stat_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      in_add  <= 1'b0;
      inv_dbl <= 1'b0;
      stat_q  <= 1'b0;
    end else begin
      state   <= state_next;
      in_add  <= in_add_next;
      inv_dbl <= inv_dbl_next;
      stat_q  <= stat_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_add_next  = in_add;
    inv_dbl_next = inv_dbl;
    stat_next    = stat_q;
    in_stall     = (state != ST_IDLE);
    cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_NOP, ecsm_pkg::REG_RX, ecsm_pkg::REG_RX,
                           ecsm_pkg::REG_RX);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_LOAD, ecsm_pkg::REG_RX, ecsm_pkg::REG_RX,
                                 ecsm_pkg::REG_RX);
          state_next = ST_RA;
        end
      end
      // reduce coefficient and coordinates by multiplying with one
      ST_RA: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_MUL, ecsm_pkg::REG_A, ecsm_pkg::REG_CFG_A,
                               ecsm_pkg::REG_ONE);
        if (stat.mul_done) state_next = ST_RPX;
      end
      ST_RPX: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_MUL, ecsm_pkg::REG_PX, ecsm_pkg::REG_RAW_PX,
                               ecsm_pkg::REG_ONE);
        if (stat.mul_done) state_next = ST_RPY;
      end
      ST_RPY: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_MUL, ecsm_pkg::REG_PY, ecsm_pkg::REG_RAW_PY,
                               ecsm_pkg::REG_ONE);
        if (stat.mul_done) state_next = ST_RQX;
      end
      ST_RQX: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_MUL, ecsm_pkg::REG_QX, ecsm_pkg::REG_RAW_QX,
                               ecsm_pkg::REG_ONE);
        if (stat.mul_done) state_next = ST_RQY;
      end
      ST_RQY: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_MUL, ecsm_pkg::REG_QY, ecsm_pkg::REG_RAW_QY,
                               ecsm_pkg::REG_ONE);
        if (stat.mul_done) state_next = ST_DISP;
      end
      ST_DISP: begin
        stat_next = 1'b0;
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_RLDP, ecsm_pkg::REG_RX, ecsm_pkg::REG_RX,
                               ecsm_pkg::REG_RX);
        case (stat.op)
          ecsm_pkg::OP_ADD: begin
            in_add_next = 1'b1;
            state_next  = ST_ACHK;
          end
          ecsm_pkg::OP_DBL: begin
            in_add_next = 1'b0;
            state_next  = ST_DCHK;
          end
          ecsm_pkg::OP_SMUL: begin
            if (stat.k_zero) begin
              cmd.code   = ecsm_pkg::CMD_CLRR;
              stat_next  = 1'b1;
              state_next = ST_OUT;
            end else begin
              state_next = ST_KINIT;
            end
          end
          default: begin
            cmd.code   = ecsm_pkg::CMD_CLRR;
            state_next = ST_OUT;
          end
        endcase
      end
      ST_KINIT: begin
        cmd.code   = ecsm_pkg::CMD_KINIT;
        state_next = ST_KQ;
      end
      ST_KQ: begin
        cmd.code   = ecsm_pkg::CMD_QLDP;
        state_next = ST_KFIND;
      end
      // skip leading zeros down to the top set bit
      ST_KFIND: begin
        if (stat.k_msb || stat.cnt_zero) state_next = ST_KNEXT;
        else cmd.code = ecsm_pkg::CMD_KSHL;
      end
      ST_KNEXT: begin
        if (stat.cnt_zero) begin
          state_next = ST_OUT;
        end else begin
          cmd.code    = ecsm_pkg::CMD_KSHL;
          in_add_next = 1'b0;
          state_next  = ST_DCHK;
        end
      end
      // point add, R = R + Q
      ST_ACHK: begin
        if (stat.r_inf) begin
          cmd.code   = ecsm_pkg::CMD_RLDQ;
          state_next = ST_FADD;
        end else if (stat.q_inf) begin
          state_next = ST_FADD;
        end else if (stat.eq_x) begin
          if (stat.eq_y) begin
            state_next = ST_DCHK;
          end else begin
            cmd.code   = ecsm_pkg::CMD_CLRR;
            state_next = ST_FADD;
          end
        end else begin
          state_next = ST_A1;
        end
      end
      ST_A1: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_SUB, ecsm_pkg::REG_T1, ecsm_pkg::REG_QX,
                               ecsm_pkg::REG_RX);
        inv_dbl_next = 1'b0;
        state_next   = ST_INV0;
      end
      ST_A2: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_SUB, ecsm_pkg::REG_T1, ecsm_pkg::REG_QY,
                               ecsm_pkg::REG_RY);
        state_next = ST_A3;
      end
      ST_A3: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_MUL, ecsm_pkg::REG_LAM, ecsm_pkg::REG_T1,
                               ecsm_pkg::REG_IA);
        if (stat.mul_done) state_next = ST_A4;
      end
      ST_A4: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_MUL, ecsm_pkg::REG_T1, ecsm_pkg::REG_LAM,
                               ecsm_pkg::REG_LAM);
        if (stat.mul_done) state_next = ST_A5;
      end
      ST_A5: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_SUB, ecsm_pkg::REG_T1, ecsm_pkg::REG_T1,
                               ecsm_pkg::REG_RX);
        state_next = ST_A6;
      end
      ST_A6: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_SUB, ecsm_pkg::REG_T1, ecsm_pkg::REG_T1,
                               ecsm_pkg::REG_QX);
        state_next = ST_A7;
      end
      ST_A7: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_SUB, ecsm_pkg::REG_T2, ecsm_pkg::REG_RX,
                               ecsm_pkg::REG_T1);
        state_next = ST_A8;
      end
      ST_A8: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_MUL, ecsm_pkg::REG_T2, ecsm_pkg::REG_LAM,
                               ecsm_pkg::REG_T2);
        if (stat.mul_done) state_next = ST_A9;
      end
      ST_A9: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_SUB, ecsm_pkg::REG_RY, ecsm_pkg::REG_T2,
                               ecsm_pkg::REG_RY);
        state_next = ST_A10;
      end
      ST_A10: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_MOV, ecsm_pkg::REG_RX, ecsm_pkg::REG_T1,
                               ecsm_pkg::REG_T1);
        state_next = ST_FADD;
      end
      // point double, R = 2R
      ST_DCHK: begin
        if (stat.r_inf || stat.ry_zero) begin
          cmd.code   = ecsm_pkg::CMD_CLRR;
          state_next = ST_FDBL;
        end else begin
          state_next = ST_D1;
        end
      end
      ST_D1: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_ADD, ecsm_pkg::REG_T1, ecsm_pkg::REG_RY,
                               ecsm_pkg::REG_RY);
        inv_dbl_next = 1'b1;
        state_next   = ST_INV0;
      end
      ST_D2: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_MUL, ecsm_pkg::REG_T1, ecsm_pkg::REG_RX,
                               ecsm_pkg::REG_RX);
        if (stat.mul_done) state_next = ST_D3;
      end
      ST_D3: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_ADD, ecsm_pkg::REG_T2, ecsm_pkg::REG_T1,
                               ecsm_pkg::REG_T1);
        state_next = ST_D4;
      end
      ST_D4: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_ADD, ecsm_pkg::REG_T1, ecsm_pkg::REG_T2,
                               ecsm_pkg::REG_T1);
        state_next = ST_D5;
      end
      ST_D5: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_ADD, ecsm_pkg::REG_T1, ecsm_pkg::REG_T1,
                               ecsm_pkg::REG_A);
        state_next = ST_D6;
      end
      ST_D6: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_MUL, ecsm_pkg::REG_LAM, ecsm_pkg::REG_T1,
                               ecsm_pkg::REG_IA);
        if (stat.mul_done) state_next = ST_D7;
      end
      ST_D7: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_MUL, ecsm_pkg::REG_T1, ecsm_pkg::REG_LAM,
                               ecsm_pkg::REG_LAM);
        if (stat.mul_done) state_next = ST_D8;
      end
      ST_D8: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_SUB, ecsm_pkg::REG_T1, ecsm_pkg::REG_T1,
                               ecsm_pkg::REG_RX);
        state_next = ST_D9;
      end
      ST_D9: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_SUB, ecsm_pkg::REG_T1, ecsm_pkg::REG_T1,
                               ecsm_pkg::REG_RX);
        state_next = ST_D10;
      end
      ST_D10: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_SUB, ecsm_pkg::REG_T2, ecsm_pkg::REG_RX,
                               ecsm_pkg::REG_T1);
        state_next = ST_D11;
      end
      ST_D11: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_MUL, ecsm_pkg::REG_T2, ecsm_pkg::REG_LAM,
                               ecsm_pkg::REG_T2);
        if (stat.mul_done) state_next = ST_D12;
      end
      ST_D12: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_SUB, ecsm_pkg::REG_RY, ecsm_pkg::REG_T2,
                               ecsm_pkg::REG_RY);
        state_next = ST_D13;
      end
      ST_D13: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_MOV, ecsm_pkg::REG_RX, ecsm_pkg::REG_T1,
                               ecsm_pkg::REG_T1);
        state_next = ST_FDBL;
      end
      // inverse of t1 as t1^(m-2), result in ia
      ST_INV0: begin
        cmd.code   = ecsm_pkg::CMD_IINIT;
        state_next = ST_INVL;
      end
      ST_INVL: begin
        if (stat.e_zero) state_next = inv_dbl ? ST_D2 : ST_A2;
        else if (stat.e_lsb) state_next = ST_INVM;
        else state_next = ST_INVS;
      end
      ST_INVM: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_MUL, ecsm_pkg::REG_IA, ecsm_pkg::REG_IA,
                               ecsm_pkg::REG_IB);
        if (stat.mul_done) state_next = ST_INVS;
      end
      ST_INVS: begin
        cmd = ecsm_pkg::mk_cmd(ecsm_pkg::CMD_MUL, ecsm_pkg::REG_IB, ecsm_pkg::REG_IB,
                               ecsm_pkg::REG_IB);
        if (stat.mul_done) state_next = ST_INVSH;
      end
      ST_INVSH: begin
        cmd.code   = ecsm_pkg::CMD_ESHR;
        state_next = ST_INVL;
      end
      ST_FDBL: begin
        if (!in_add && (stat.op == ecsm_pkg::OP_SMUL) && stat.k_msb) begin
          in_add_next = 1'b1;
          state_next  = ST_ACHK;
        end else begin
          state_next = ST_FADD;
        end
      end
      ST_FADD: begin
        state_next = (stat.op == ecsm_pkg::OP_SMUL) ? ST_KNEXT : ST_OUT;
      end
      ST_OUT: begin
        if (!stat.out_busy) begin
          cmd.code   = ecsm_pkg::CMD_OUT;
          cmd.ostat  = stat_q;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/ec_point_scalar_multiply.sv]
// top level of the affine elliptic-curve point unit over a small prime field
// depends on ecsm_pkg, ecsm_ctrl and ecsm_dp
`timescale 1ns / 1ps
`default_nettype none

// channel   direction   handshake              payload
// in        to block    in_valid / in_stall    in_item  (op, p_x, p_y, q_x, q_y, scalar)
// out       from block  out_valid / out_stall  out_item (r_x, r_y, status)
// cfg       to block    cfg_we                 cfg_index, cfg_data
//
// one item at a time; every field product goes through one bit-serial multiplier
// an inversion is up to 2 * FIELD_BITS products
// synchronous reset clears the sequencer, the output valid and loads
// curve_a = 2, field_prime = 5
// a stalled result sits in the output register; the next item is taken
// meanwhile and its result waits until that register is free

module ec_point_scalar_multiply (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire ecsm_pkg::in_item_t                 in_item,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output ecsm_pkg::out_item_t                     out_item,
  input  wire logic                               cfg_we,
  input  wire logic [ecsm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire ecsm_pkg::field_t                   cfg_data
);

  // command and status between sequencer and datapath
  ecsm_pkg::dp_cmd_t  cmd;
  ecsm_pkg::dp_stat_t stat;

  ecsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ecsm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

[rtl/core/ecsm_checker.sv]
// port-level checks for the elliptic-curve point unit, bound to the top level
// depends on ecsm_pkg
`timescale 1ns / 1ps
`default_nettype none

module ecsm_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire ecsm_pkg::out_item_t                out_item
);

  // one item at a time: accepting closes the input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after an accept");

  // a zero-scalar error always carries the point at infinity
  a_err_inf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status) |-> (out_item.r_x == '0 && out_item.r_y == '0))
    else $error("error status with a finite point");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ec_point_scalar_multiply ecsm_checker u_chk (.*);

`default_nettype wire
